// ----- sv/price_level_order_book_core_macros.svh -----
// Assertion macros shared by the order book RTL
`ifndef PRICE_LEVEL_ORDER_BOOK_CORE_MACROS_SVH
`define PRICE_LEVEL_ORDER_BOOK_CORE_MACROS_SVH

`ifndef SYNTHESIS
// expression holds at every clock edge out of reset
`define PLOB_ASSERT_ALW(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("order book check failed");
// antecedent implies consequent in the same cycle
`define PLOB_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("order book check failed");
`else
`define PLOB_ASSERT_ALW(lbl, clk, rst_n, expr)
`define PLOB_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ----- sv/plob_pkg.sv -----
package plob_pkg;

    // levels kept per side
    localparam int LEVELS  = 64;
    localparam int PRICE_W = 32;
    localparam int QTY_W   = 32;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_DELETE,
        OP_CANCEL,
        OP_REPLACE
    } t_opcode;

    typedef enum logic [1:0] {
        STAT_OK,
        STAT_NOT_FOUND,
        STAT_FULL
    } t_status;

    // command broadcast to every cell of a side
    typedef enum logic [1:0] {
        CO_NONE,
        CO_CMP,
        CO_ADD,
        CO_TAKE
    } t_cell_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP1,
        S_UPD1,
        S_CMP2,
        S_UPD2,
        S_RESP
    } t_state;

    typedef struct packed {
        logic               valid;
        logic [PRICE_W-1:0] price;
        logic [QTY_W-1:0]   qty;
    } t_level;

    typedef struct packed {
        logic better;   // level sorts strictly ahead of the key price
        logic eq;       // level price equals the key price
        logic eq_new;   // level price equals the auxiliary price
        logic le;       // level qty <= key qty
    } t_cell_flags;

    typedef struct packed {
        t_cell_op           op;
        logic               hit;      // add lands on an existing level
        logic               remove;   // take removes the matched level
        logic [PRICE_W-1:0] key_price;
        logic [QTY_W-1:0]   key_qty;
        logic [PRICE_W-1:0] aux_price;
    } t_cell_cmd;

    typedef struct packed {
        logic any_eq;
        logic any_rm;
        logic any_eq_new;
        logic full;
    } t_chain_stat;

endpackage

// ----- sv/plob_cell.sv -----
module plob_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_is_ask,
    input  plob_pkg::t_cell_cmd   i_cmd,
    input  plob_pkg::t_level      i_left,
    input  logic                  i_left_better,
    input  plob_pkg::t_level      i_right,
    output plob_pkg::t_level      o_level,
    output plob_pkg::t_cell_flags o_flags
);
    import plob_pkg::*;

    t_level            r_level;
    t_level            n_level;
    t_cell_flags       r_flags;
    t_cell_flags       n_flags;
    logic [QTY_W:0]    w_sum;
    logic [QTY_W-1:0]  w_sat;

    // compare pass: flags against the broadcast key
    always_comb begin
        n_flags = r_flags;
        if (i_cmd.op == CO_CMP) begin
            n_flags.better = r_level.valid &&
                (i_is_ask ? (r_level.price < i_cmd.key_price)
                          : (r_level.price > i_cmd.key_price));
            n_flags.eq     = r_level.valid && (r_level.price == i_cmd.key_price);
            n_flags.eq_new = r_level.valid && (r_level.price == i_cmd.aux_price);
            n_flags.le     = (r_level.qty <= i_cmd.key_qty);
        end
    end

    // saturating add onto the level
    assign w_sum = {1'b0, r_level.qty} + {1'b0, i_cmd.key_qty};
    assign w_sat = w_sum[QTY_W] ? {QTY_W{1'b1}} : w_sum[QTY_W-1:0];

    // update pass: hold, modify, or shift from a neighbor
    always_comb begin
        n_level = r_level;
        unique case (i_cmd.op)
            CO_ADD: begin
                if (i_cmd.hit) begin
                    if (r_flags.eq) n_level.qty = w_sat;
                end else if (!r_flags.better) begin
                    if (i_left_better) begin
                        n_level = '{valid: 1'b1, price: i_cmd.key_price,
                                    qty: i_cmd.key_qty};
                    end else begin
                        n_level = i_left;
                    end
                end
            end
            CO_TAKE: begin
                if (i_cmd.remove) begin
                    if (!r_flags.better) n_level = i_right;
                end else if (r_flags.eq) begin
                    n_level.qty = r_level.qty - i_cmd.key_qty;
                end
            end
            default: ;
        endcase
    end

    // valid bit and flags reset; price and quantity are don't-care while invalid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level.valid <= 1'b0;
            r_flags       <= '0;
        end else begin
            r_level.valid <= n_level.valid;
            r_flags       <= n_flags;
        end
        r_level.price <= n_level.price;
        r_level.qty   <= n_level.qty;
    end

    assign o_level = r_level;
    assign o_flags = r_flags;

endmodule

// ----- sv/plob_chain.sv -----
`include "price_level_order_book_core_macros.svh"

module plob_chain (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_is_ask,
    input  plob_pkg::t_cell_cmd   i_cmd,
    output plob_pkg::t_chain_stat o_stat,
    output plob_pkg::t_level      o_best
);
    import plob_pkg::*;

    t_level              w_lvl        [LEVELS];
    t_cell_flags         w_flg        [LEVELS];
    t_level              w_left       [LEVELS];
    logic                w_left_better[LEVELS];
    t_level              w_right      [LEVELS];
    logic [LEVELS-1:0]   w_valid;
    logic [LEVELS-1:0]   w_eq;
    logic [LEVELS-1:0]   w_rm;
    logic [LEVELS-1:0]   w_eq_new;

    // row of level cells, best level in cell 0
    for (genvar g = 0; g < LEVELS; g++) begin : g_cell
        if (g == 0) begin : g_head
            assign w_left[g]        = '0;
            assign w_left_better[g] = 1'b1;
        end else begin : g_body
            assign w_left[g]        = w_lvl[g-1];
            assign w_left_better[g] = w_flg[g-1].better;
        end
        if (g == LEVELS - 1) begin : g_tail
            assign w_right[g] = '0;
        end else begin : g_mid
            assign w_right[g] = w_lvl[g+1];
        end

        plob_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_is_ask     (i_is_ask),
            .i_cmd        (i_cmd),
            .i_left       (w_left[g]),
            .i_left_better(w_left_better[g]),
            .i_right      (w_right[g]),
            .o_level      (w_lvl[g]),
            .o_flags      (w_flg[g])
        );

        assign w_valid[g]  = w_lvl[g].valid;
        assign w_eq[g]     = w_flg[g].eq;
        assign w_rm[g]     = w_flg[g].eq & w_flg[g].le;
        assign w_eq_new[g] = w_flg[g].eq_new;
    end

    // side summary from the registered compare flags and cell valid bits, plus the best level
    assign o_stat.any_eq     = |w_eq;
    assign o_stat.any_rm     = |w_rm;
    assign o_stat.any_eq_new = |w_eq_new;
    assign o_stat.full       = w_valid[LEVELS-1];
    assign o_best            = w_lvl[0];

    // occupied cells form a prefix, at most one level matches the key price, and the head two levels are sorted
    `PLOB_ASSERT_ALW(a_valid_prefix, i_clk, i_rst_n,
                     (w_valid & (w_valid + LEVELS'(1))) == '0)
    `PLOB_ASSERT_ALW(a_eq_unique, i_clk, i_rst_n, $onehot0(w_eq))
    `PLOB_ASSERT_IMP(a_head_sorted, i_clk, i_rst_n, w_valid[1],
                     i_is_ask ? (w_lvl[0].price < w_lvl[1].price)
                              : (w_lvl[0].price > w_lvl[1].price))

endmodule

// ----- sv/price_level_order_book_core.sv -----
// A request passes the states S_CMP1, S_UPD1 and S_RESP; a replace whose delete part finds
// its level and leaves room for the add part passes S_CMP2 and S_UPD2 before S_RESP too.
// A new request is not taken while another is in flight; each request makes one compare pass
// and one update pass through the cell chain, two passes for that replace.
// The next request is taken in the cycle its predecessor's result is registered; a result
// still waiting in the output register holds off both. Reset (synchronous, active low)
// empties both sides by clearing the cell valid bits.
`include "price_level_order_book_core_macros.svh"

module price_level_order_book_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_opcode,
    input  logic        i_side,
    input  logic [31:0] i_price,
    input  logic [31:0] i_order_qty,
    input  logic [31:0] i_cancel_qty,
    input  logic [31:0] i_new_price,
    input  logic [31:0] i_new_qty,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [31:0] o_best_bid_price,
    output logic [31:0] o_best_bid_qty,
    output logic [31:0] o_best_ask_price,
    output logic [31:0] o_best_ask_qty
);
    import plob_pkg::*;

    t_state             r_state;
    t_state             n_state;
    t_opcode            r_op;
    logic               r_side;
    logic [PRICE_W-1:0] r_price;
    logic [QTY_W-1:0]   r_qty;
    logic [PRICE_W-1:0] r_new_price;
    logic [QTY_W-1:0]   r_new_qty;
    t_status            r_stat;
    t_status            n_stat;
    logic               r_out_valid;
    t_status            r_out_status;
    logic [PRICE_W-1:0] r_out_bbp;
    logic [QTY_W-1:0]   r_out_bbq;
    logic [PRICE_W-1:0] r_out_bap;
    logic [QTY_W-1:0]   r_out_baq;

    t_cell_cmd          w_cmd;
    t_cell_cmd          w_cmd_bid;
    t_cell_cmd          w_cmd_ask;
    t_chain_stat        w_bid_stat;
    t_chain_stat        w_ask_stat;
    t_chain_stat        w_sel_stat;
    t_level             w_bid_best;
    t_level             w_ask_best;
    logic               w_accept;
    logic               w_load;
    logic               w_rep_ok;
    logic               w_second;
    logic [QTY_W-1:0]   w_take_qty;

    assign w_sel_stat = r_side ? w_ask_stat : w_bid_stat;
    assign w_second   = (r_state == S_CMP2) || (r_state == S_UPD2);
    assign w_accept   = i_valid && o_ready;

    // replace goes ahead if its level is found and its add would not need a level on a full side
    assign w_rep_ok = w_sel_stat.any_eq &&
                      !(!w_sel_stat.any_rm && w_sel_stat.full && !w_sel_stat.any_eq_new);

    // cancel takes off at most the order's remaining quantity
    assign w_take_qty = (t_opcode'(i_opcode) == OP_CANCEL && i_cancel_qty < i_order_qty)
                        ? i_cancel_qty : i_order_qty;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_accept) n_state = S_CMP1;
            S_CMP1: n_state = S_UPD1;
            S_UPD1: n_state = (r_op == OP_REPLACE && w_rep_ok) ? S_CMP2 : S_RESP;
            S_CMP2: n_state = S_UPD2;
            S_UPD2: n_state = S_RESP;
            S_RESP: begin
                if (w_load) n_state = w_accept ? S_CMP1 : S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs: chain command, status, result load, request ready
    always_comb begin
        w_cmd.op        = CO_NONE;
        w_cmd.hit       = 1'b0;
        w_cmd.remove    = 1'b0;
        w_cmd.key_price = w_second ? r_new_price : r_price;
        w_cmd.key_qty   = w_second ? r_new_qty : r_qty;
        w_cmd.aux_price = r_new_price;
        n_stat          = r_stat;
        w_load          = 1'b0;
        o_ready         = 1'b0;
        unique case (r_state)
            S_IDLE: o_ready = 1'b1;
            S_CMP1, S_CMP2: w_cmd.op = CO_CMP;
            S_UPD1: begin
                unique case (r_op) inside
                    OP_ADD: begin
                        w_cmd.hit = w_sel_stat.any_eq;
                        if (w_sel_stat.any_eq || !w_sel_stat.full) begin
                            w_cmd.op = CO_ADD;
                            n_stat   = STAT_OK;
                        end else begin
                            n_stat   = STAT_FULL;
                        end
                    end
                    OP_DELETE, OP_CANCEL: begin
                        w_cmd.remove = w_sel_stat.any_rm;
                        if (w_sel_stat.any_eq) begin
                            w_cmd.op = CO_TAKE;
                            n_stat   = STAT_OK;
                        end else begin
                            n_stat   = STAT_NOT_FOUND;
                        end
                    end
                    OP_REPLACE: begin
                        w_cmd.remove = w_sel_stat.any_rm;
                        if (!w_sel_stat.any_eq) begin
                            n_stat   = STAT_NOT_FOUND;
                        end else if (!w_rep_ok) begin
                            n_stat   = STAT_FULL;
                        end else begin
                            w_cmd.op = CO_TAKE;
                            n_stat   = STAT_OK;
                        end
                    end
                    default: ;
                endcase
            end
            S_UPD2: begin
                w_cmd.op  = CO_ADD;
                w_cmd.hit = w_sel_stat.any_eq;
                n_stat    = STAT_OK;
            end
            S_RESP: begin
                w_load  = !r_out_valid || i_ready;
                o_ready = w_load;
            end
            default: ;
        endcase
    end

    // only the addressed side sees the command
    always_comb begin
        w_cmd_bid = w_cmd;
        w_cmd_ask = w_cmd;
        if (r_side) w_cmd_bid.op = CO_NONE;
        else        w_cmd_ask.op = CO_NONE;
    end

    plob_chain u_bid (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_is_ask(1'b0),
        .i_cmd  (w_cmd_bid),
        .o_stat (w_bid_stat),
        .o_best (w_bid_best)
    );

    plob_chain u_ask (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_is_ask(1'b1),
        .i_cmd  (w_cmd_ask),
        .o_stat (w_ask_stat),
        .o_best (w_ask_best)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load)       r_out_valid <= 1'b1;
            else if (i_ready) r_out_valid <= 1'b0;
        end
    end

    // request capture, status and result registers
    always_ff @(posedge i_clk) begin
        r_stat <= n_stat;
        if (w_accept) begin
            r_op        <= t_opcode'(i_opcode);
            r_side      <= i_side;
            r_price     <= i_price;
            r_qty       <= w_take_qty;
            r_new_price <= i_new_price;
            r_new_qty   <= i_new_qty;
        end
        if (w_load) begin
            r_out_status <= r_stat;
            r_out_bbp    <= w_bid_best.valid ? w_bid_best.price : '0;
            r_out_bbq    <= w_bid_best.valid ? w_bid_best.qty : '0;
            r_out_bap    <= w_ask_best.valid ? w_ask_best.price : '0;
            r_out_baq    <= w_ask_best.valid ? w_ask_best.qty : '0;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_status         = r_out_status;
    assign o_best_bid_price = r_out_bbp;
    assign o_best_bid_qty   = r_out_bbq;
    assign o_best_ask_price = r_out_bap;
    assign o_best_ask_qty   = r_out_baq;

    // second pass belongs to a replace that has room for its add
    `PLOB_ASSERT_IMP(a_upd2_replace, i_clk, i_rst_n, r_state == S_UPD2, r_op == OP_REPLACE)
    `PLOB_ASSERT_IMP(a_upd2_room, i_clk, i_rst_n, r_state == S_UPD2,
                     w_sel_stat.any_eq || !w_sel_stat.full)
    `PLOB_ASSERT_IMP(a_result_from_resp, i_clk, i_rst_n, $rose(o_valid),
                     $past(r_state == S_RESP))

endmodule
